>>> rtl/kas_pkg.sv
// ----------------------------------------------------------------------------
// kas_pkg
// shared types and constants of the keyed array store
// ----------------------------------------------------------------------------
`default_nettype none

package kas_pkg;

	localparam int NUM_ARRAYS_DEF  = 8;
	localparam int MAX_ENTRIES_DEF = 32;
	localparam int KEY_CHARS_DEF   = 8;

	typedef enum logic [1:0] {
		KIND_CREATE = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_SORT   = 2'd2,
		KIND_READ   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_DONE     = 3'd0,
		ST_NOTFOUND = 3'd1,
		ST_ERROR    = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_VALUE    = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIND,
		S_DISPATCH,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_SORT_RDA,
		S_SORT_RDB,
		S_SORT_CMP,
		S_SORT_WRB,
		S_READ_RD,
		S_READ_OUT,
		S_RESULT
	} state_t;

endpackage

`default_nettype wire

>>> rtl/keyed_array_store_insert_sort_core.sv
// ----------------------------------------------------------------------------
// keyed_array_store_insert_sort_core
// table of named integer arrays with create, insert, exchange sort and read
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  in      | in_valid in_ready kind key position ...  | into block
//  out     | out_valid out_ready status data last     | out of block
//
//  one item at a time through a sequencer around a dual-port element memory;
//  create: result in the cycle after the transfer; lookup walks the key table
//  one slot a cycle, then dispatches; insert: read and write per written entry,
//  new value included; sort: read per outer pass, read and compare per compare,
//  write-back per swap (n*(n-1)/2 compares); read: read and output per value;
//  reset clears the used flags and state only; stalls on out hold the sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_array_store_insert_sort_core #(
	parameter int NUM_ARRAYS  = kas_pkg::NUM_ARRAYS_DEF,
	parameter int MAX_ENTRIES = kas_pkg::MAX_ENTRIES_DEF,
	parameter int KEY_CHARS   = kas_pkg::KEY_CHARS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         kind,
	input  wire logic [63:0]        key,
	input  wire logic [5:0]         position,
	input  wire logic signed [31:0] value,
	input  wire logic               descending,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [2:0]              status,
	output logic signed [31:0]      data,
	output logic                    last
);
	import kas_pkg::*;

	localparam int SW = (NUM_ARRAYS > 1) ? $clog2(NUM_ARRAYS) : 1;
	localparam int EW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int KW = 8 * KEY_CHARS;
	localparam int DEPTH = NUM_ARRAYS * MAX_ENTRIES;
	localparam int AW = SW + EW;

	logic [NUM_ARRAYS-1:0] used_q;
	logic [KW-1:0]         key_mem [NUM_ARRAYS];
	logic [CW-1:0]         cnt_mem [NUM_ARRAYS];
	logic [31:0]           el_mem  [DEPTH];

	state_t state_q, state_d;
	kind_t  kind_q;
	logic [KW-1:0] key_q;
	logic [5:0]    pos_q;
	logic [31:0]   val_q;
	logic          desc_q;
	logic [SW-1:0] slot_q;
	logic          found_q;
	logic [CW-1:0] n_q, i_q, j_q;
	logic [31:0]   a_q, rd_q;
	logic          a_load_q;
	logic [2:0]    st_q;
	logic          last_q;

	logic          mem_we;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [31:0]   mem_wd;

	function automatic logic [AW-1:0] addr(input logic [SW-1:0] s, input logic [CW-1:0] e);
		logic [31:0] t;
		t = 32'(s) * 32'(MAX_ENTRIES) + 32'(e);
		return t[AW-1:0];
	endfunction

	// element memory
	always_ff @(posedge clk) begin
		if (mem_we) el_mem[mem_wa] <= mem_wd;
		rd_q <= el_mem[mem_ra];
	end

	logic free_any;
	logic [SW-1:0] free_idx;
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int s = NUM_ARRAYS - 1; s >= 0; s--)
			if (!used_q[s]) begin
				free_any = 1'b1;
				free_idx = SW'(s);
			end
	end

	logic hit;
	assign hit = used_q[slot_q] && (key_mem[slot_q] == key_q);

	logic swap;
	assign swap = desc_q ? ($signed(rd_q) > $signed(a_q)) : ($signed(a_q) > $signed(rd_q));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_d = (kind_t'(kind) == KIND_CREATE) ? S_RESULT : S_FIND;
			S_FIND: if (hit || slot_q == SW'(NUM_ARRAYS - 1)) state_d = S_DISPATCH;
			S_DISPATCH: begin
				if (!found_q && !hit) state_d = S_RESULT;
				else case (kind_q)
					KIND_INSERT: state_d = (CW'(pos_q) > n_q || n_q >= CW'(MAX_ENTRIES))
						? S_RESULT : S_SHIFT_RD;
					KIND_SORT:   state_d = S_SORT_RDA;
					KIND_READ:   state_d = (n_q == '0) ? S_RESULT : S_READ_RD;
					default:     state_d = S_RESULT;
				endcase
			end
			S_SHIFT_RD: state_d = S_SHIFT_WR;
			S_SHIFT_WR: state_d = (i_q == CW'(pos_q)) ? S_RESULT : S_SHIFT_RD;
			S_SORT_RDA: state_d = (i_q + 1'b1 >= n_q) ? S_RESULT : S_SORT_RDB;
			S_SORT_RDB: state_d = S_SORT_CMP;
			S_SORT_CMP: state_d = swap ? S_SORT_WRB : S_SORT_RDB;
			S_SORT_WRB: state_d = S_SORT_RDB;
			S_READ_RD:  state_d = S_READ_OUT;
			S_READ_OUT: if (out_ready) state_d = last_q ? S_IDLE : S_READ_RD;
			S_RESULT:   if (out_ready) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
		// sort inner loop end
		if ((state_q == S_SORT_CMP || state_q == S_SORT_WRB) && state_d == S_SORT_RDB
			&& j_q + 1'b1 >= n_q)
			state_d = S_SORT_RDA;
	end

	// outputs
	always_comb begin
		in_ready  = (state_q == S_IDLE);
		out_valid = (state_q == S_RESULT) || (state_q == S_READ_OUT);
		status    = (state_q == S_READ_OUT) ? 3'(ST_VALUE) : st_q;
		data      = (state_q == S_READ_OUT) ? $signed(rd_q) : 32'sd0;
		last      = (state_q == S_READ_OUT) ? last_q : 1'b1;
		mem_we = 1'b0;
		mem_wa = addr(slot_q, i_q);
		mem_wd = rd_q;
		mem_ra = addr(slot_q, i_q - 1'b1);
		case (state_q)
			S_SHIFT_WR: begin
				mem_we = 1'b1;
				if (i_q == CW'(pos_q)) mem_wd = val_q;
			end
			S_SORT_RDA: mem_ra = addr(slot_q, i_q);
			S_SORT_RDB: mem_ra = addr(slot_q, j_q);
			// old element i goes to j, element j follows into i next cycle
			S_SORT_CMP: begin
				mem_we = swap;
				mem_wa = addr(slot_q, j_q);
				mem_wd = a_q;
			end
			S_SORT_WRB: begin
				mem_we = 1'b1;
				mem_wd = a_q;
			end
			S_READ_RD:  mem_ra = addr(slot_q, i_q);
			S_READ_OUT: mem_ra = addr(slot_q, i_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && in_valid && kind_t'(kind) == KIND_CREATE && free_any)
				used_q[free_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		a_load_q <= (state_q == S_SORT_RDA);
		case (state_q)
			S_IDLE: if (in_valid) begin
				kind_q  <= kind_t'(kind);
				key_q   <= key[KW-1:0];
				pos_q   <= position;
				val_q   <= value;
				desc_q  <= descending;
				slot_q  <= '0;
				found_q <= 1'b0;
				if (kind_t'(kind) == KIND_CREATE) begin
					st_q <= free_any ? 3'(ST_DONE) : 3'(ST_ERROR);
					if (free_any) begin
						key_mem[free_idx] <= key[KW-1:0];
						cnt_mem[free_idx] <= '0;
					end
				end
			end
			S_FIND: begin
				if (hit) begin
					found_q <= 1'b1;
					n_q     <= cnt_mem[slot_q];
				end else if (slot_q != SW'(NUM_ARRAYS - 1)) slot_q <= slot_q + 1'b1;
			end
			S_DISPATCH: begin
				if (!found_q) st_q <= 3'(ST_NOTFOUND);
				else case (kind_q)
					KIND_INSERT: begin
						i_q <= n_q;
						if (CW'(pos_q) > n_q || n_q >= CW'(MAX_ENTRIES)) st_q <= 3'(ST_ERROR);
						else begin
							st_q <= 3'(ST_DONE);
							cnt_mem[slot_q] <= n_q + 1'b1;
						end
					end
					KIND_SORT: begin
						i_q  <= '0;
						st_q <= 3'(ST_DONE);
					end
					KIND_READ: begin
						i_q  <= '0;
						st_q <= (n_q == '0) ? 3'(ST_EMPTY) : 3'(ST_DONE);
					end
					default: st_q <= 3'(ST_DONE);
				endcase
			end
			S_SHIFT_WR: i_q <= i_q - 1'b1;
			S_SORT_RDA: j_q <= i_q + 1'b1;
			// a_q holds element i
			S_SORT_RDB: if (a_load_q) a_q <= rd_q;
			S_SORT_CMP: begin
				if (swap) a_q <= rd_q;
				else if (state_d == S_SORT_RDB) j_q <= j_q + 1'b1;
				else i_q <= i_q + 1'b1;
			end
			S_SORT_WRB: begin
				if (state_d == S_SORT_RDB) j_q <= j_q + 1'b1;
				else i_q <= i_q + 1'b1;
			end
			S_READ_RD:  last_q <= (i_q + 1'b1 == n_q);
			S_READ_OUT: if (out_ready) i_q <= i_q + 1'b1;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

>>> bench/keyed_array_store_insert_sort_checker.sv
// ----------------------------------------------------------------------------
// keyed_array_store_insert_sort_checker
// watches both channels, predicts results of every transfer and compares them
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_array_store_insert_sort_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic [1:0]         kind,
	input  wire logic [63:0]        key,
	input  wire logic [5:0]         position,
	input  wire logic signed [31:0] value,
	input  wire logic               descending,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic [2:0]         status,
	input  wire logic signed [31:0] data,
	input  wire logic               last,
	output int                      errors,
	output int                      pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import kas_pkg::*;

	localparam int NA = NUM_ARRAYS_DEF;
	localparam int ME = MAX_ENTRIES_DEF;

	typedef struct packed {
		logic [2:0]         st;
		logic signed [31:0] val;
		logic               lst;
	} result_t;

	result_t             results_due[$];
	bit                  used[NA];
	logic [63:0]         names[NA];
	int                  counts[NA];
	logic signed [31:0]  elems[NA][ME];

	function automatic result_t mk(status_t s, logic signed [31:0] v, bit l);
		result_t r;
		r.st = s;
		r.val = v;
		r.lst = l;
		return r;
	endfunction

	function automatic int lookup(logic [63:0] k);
		for (int s = 0; s < NA; s++)
			if (used[s] && names[s] == k)
				return s;
		return -1;
	endfunction

	task automatic apply_command(kind_t kd, logic [63:0] k, int pos, logic signed [31:0] v,
			bit desc);
		int s;
		int n;
		logic signed [31:0] a;
		logic signed [31:0] b;
		if (kd == KIND_CREATE) begin
			for (s = 0; s < NA; s++)
				if (!used[s])
					break;
			if (s == NA) begin
				results_due.push_back(mk(ST_ERROR, 0, 1));
			end else begin
				used[s] = 1;
				names[s] = k;
				counts[s] = 0;
				results_due.push_back(mk(ST_DONE, 0, 1));
			end
			return;
		end
		s = lookup(k);
		if (s < 0) begin
			results_due.push_back(mk(ST_NOTFOUND, 0, 1));
			return;
		end
		n = counts[s];
		case (kd)
			KIND_INSERT: begin
				if (pos > n || n >= ME) begin
					results_due.push_back(mk(ST_ERROR, 0, 1));
				end else begin
					for (int i = n; i > pos; i--)
						elems[s][i] = elems[s][i-1];
					elems[s][pos] = v;
					counts[s] = n + 1;
					results_due.push_back(mk(ST_DONE, 0, 1));
				end
			end
			KIND_SORT: begin
				for (int i = 0; i < n; i++)
					for (int j = i + 1; j < n; j++) begin
						a = elems[s][i];
						b = elems[s][j];
						if (desc ? (b > a) : (a > b)) begin
							elems[s][i] = b;
							elems[s][j] = a;
						end
					end
				results_due.push_back(mk(ST_DONE, 0, 1));
			end
			default: begin
				if (n == 0)
					results_due.push_back(mk(ST_EMPTY, 0, 1));
				else
					for (int i = 0; i < n; i++)
						results_due.push_back(mk(ST_VALUE, elems[s][i], i == n - 1));
			end
		endcase
	endtask

	initial begin
		errors = 0;
		pending = 0;
		for (int s = 0; s < NA; s++)
			used[s] = 0;
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (results_due.size() == 0) begin
				errors <= errors + 1;
				if (errors < 10)
					$display("unexpected result status=%0d data=%0d last=%0b",
						status, data, last);
			end else begin
				want = results_due.pop_front();
				if (status !== want.st || data !== want.val || last !== want.lst) begin
					errors <= errors + 1;
					if (errors < 10)
						$display("mismatch: expected %0d/%0d/%0b got %0d/%0d/%0b",
							want.st, want.val, want.lst, status, data, last);
				end
			end
		end
		if (arst_n && in_valid && in_ready)
			apply_command(kind_t'(kind), key, position, value, descending);
		pending <= results_due.size();
	end
endmodule

`default_nettype wire

>>> bench/keyed_array_store_insert_sort_core_test.sv
// ----------------------------------------------------------------------------
// keyed_array_store_insert_sort_core_test
// directed and random command streams into the keyed array store, results
// checked by a predicting monitor, with bursty sender and stalling receiver
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_array_store_insert_sort_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import kas_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         kind;
	logic [63:0]        key;
	logic [5:0]         position;
	logic signed [31:0] value;
	logic               descending;
	logic               out_valid;
	logic               out_ready;
	logic [2:0]         status;
	logic signed [31:0] data;
	logic               last;
	int                 errors;
	int                 pending;
	int                 idle_cycles;
	int                 stall_mode;
	logic [63:0]        names[6];

	keyed_array_store_insert_sort_core DUT (.*);

	keyed_array_store_insert_sort_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// receiver stall pattern
	always @(posedge clk) begin
		if ($urandom_range(0, 99) == 0)
			stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= ($urandom_range(0, 7) == 0);
			default: out_ready <= ($urandom_range(0, 3) != 0);
		endcase
	end

	task automatic send(kind_t kd, logic [63:0] k, logic [5:0] pos, logic [31:0] v,
			logic desc);
		kind <= kd;
		key <= k;
		position <= pos;
		value <= v;
		descending <= desc;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic pause(int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64;
		return {$urandom, $urandom};
	endfunction

	initial begin
		int burst;
		int r;
		int sel;
		idle_cycles = 0;
		stall_mode = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		kind = KIND_CREATE;
		key = '0;
		position = '0;
		value = '0;
		descending = 1'b0;
		names[0] = 64'hFFFF_FFFF_FFFF_FFFF;
		names[1] = 64'h0;
		for (int i = 2; i < 6; i++)
			names[i] = rand64();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		send(KIND_READ, names[0], 0, 0, 0);
		send(KIND_CREATE, names[0], 0, 0, 0);
		send(KIND_READ, names[0], 0, 0, 0);
		send(KIND_INSERT, names[0], 1, 5, 0);
		send(KIND_INSERT, names[0], 0, 32'h7FFF_FFFF, 0);
		send(KIND_INSERT, names[0], 0, 32'h8000_0000, 0);
		send(KIND_INSERT, names[0], 63, 1, 0);
		send(KIND_INSERT, names[0], 3, 32'hFFFF_FFFF, 0);
		send(KIND_SORT, names[0], 0, 0, 1);
		send(KIND_READ, names[0], 0, 0, 0);
		send(KIND_SORT, names[0], 0, 0, 0);
		send(KIND_READ, names[0], 0, 0, 0);
		send(KIND_SORT, names[1], 0, 0, 0);
		send(KIND_INSERT, names[1], 0, 0, 0);
		for (int i = 0; i < 8; i++)
			send(KIND_CREATE, names[i % 2], 0, 0, 0);
		send(KIND_READ, names[1], 0, 0, 0);
		drain();

		// random: fill arrays, some to capacity; sender pauses for full drain once
		for (int n = 0; n < 32; n++) begin
			burst = $urandom_range(1, 10);
			for (int b = 0; b < burst; b++) begin
				r = $urandom_range(0, 99);
				sel = $urandom_range(0, 5);
				if (r < 4)
					send(KIND_CREATE, $urandom_range(0, 3) == 0 ? rand64() : names[sel],
						0, 0, 0);
				else if (r < 70)
					send(KIND_INSERT, names[sel],
						$urandom_range(0, 9) == 0 ? 6'($urandom) : 6'($urandom_range(0, 33)),
						$urandom, 1'($urandom_range(0, 1)));
				else if (r < 80)
					send(KIND_SORT, $urandom_range(0, 9) == 0 ? rand64() : names[sel],
						6'($urandom), $urandom, 1'($urandom_range(0, 1)));
				else
					send(KIND_READ, $urandom_range(0, 9) == 0 ? rand64() : names[sel],
						6'($urandom), $urandom, 1'($urandom_range(0, 1)));
			end
			if (n == 16)
				drain();
			else if ($urandom_range(0, 2) != 0)
				pause($urandom_range(1, 20));
		end
		drain();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

`default_nettype wire
